@@ hw/rtl/lpp_pkg.sv @@
// ============================================================================
// lpp_pkg: shared definitions for the point perspective projection block
// Default widths, register indexes and the control group that travels
// with each point through the pipeline.
// ============================================================================
package lpp_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int GAIN_BITS      = 16;
    localparam int SIZE_BITS      = 13;
    localparam int IDX_BITS       = 3;
    localparam int QCLAMP_EXP     = 62;

    localparam logic [IDX_BITS-1:0] REG_CENTRE_X   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_CENTRE_Y   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_CENTRE_Z   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_PLANE_X    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_PIXEL_GAIN = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_SCREEN_W   = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_SCREEN_H   = 3'd6;

    typedef struct packed {
        logic valid;
        logic dzero;
        logic neg_y;
        logic neg_z;
        logic rng_ovf;
    } lpp_ctl_t;

endpackage

@@ hw/rtl/lidar_point_perspective_project.sv @@
// ============================================================================
// lidar_point_perspective_project: 3-D point to picture coordinates
// Projects a fixed-point point through a centre of projection onto the
// plane x = plane_x, scales and offsets it into pixels, and gives its range.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: pos_x, pos_y, pos_z
//   m_axis    out        tdata: image_x, image_y, range_out; tuser: div_zero, overflow
//   cfg       in         write enable, register index, write data
//
// One point is taken per cycle while the output transfer is not stalled, and each
// result passes through the bit-per-stage divider chain on its way to the output.
// Reset clears every valid bit and loads the register defaults.
// When the output transfer stalls the whole pipeline holds in place.
// ============================================================================
module lidar_point_perspective_project #(
    parameter int COORD_BITS = lpp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpp_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // pos_x, pos_y, pos_z from the lowest bit up
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // image_x, image_y, range_out from the lowest bit up
    output logic [((3*COORD_BITS+7)/8)*8-1:0]           m_tdata,
    // div_zero, overflow from the lowest bit up
    output logic [1:0]                                  m_tuser,
    input  logic                                        cfg_we,
    input  logic [lpp_pkg::IDX_BITS-1:0]                cfg_index,
    input  logic [(COORD_BITS > 16 ? COORD_BITS : 16)-1:0] cfg_data
);
    import lpp_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NB  = 2 * W + 2;
    localparam int TDW = ((3 * W + 7) / 8) * 8;
    localparam int QXW = (NB > QCLAMP_EXP + 1) ? NB : QCLAMP_EXP + 1;
    localparam int QMW = QCLAMP_EXP + 1;
    localparam int VW  = QMW + 1;
    localparam int MW  = QMW + GAIN_BITS;

    logic signed [W-1:0]  centre_x_reg, centre_y_reg, centre_z_reg, plane_x_reg;
    logic [GAIN_BITS-1:0] pixel_gain_reg;
    logic [SIZE_BITS-1:0] screen_w_reg, screen_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg   <= '0;
            centre_y_reg   <= '0;
            centre_z_reg   <= '0;
            plane_x_reg    <= W'(1) << F;
            pixel_gain_reg <= GAIN_BITS'(1);
            screen_w_reg   <= SIZE_BITS'(640);
            screen_h_reg   <= SIZE_BITS'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTRE_X:   centre_x_reg   <= cfg_data[W-1:0];
                REG_CENTRE_Y:   centre_y_reg   <= cfg_data[W-1:0];
                REG_CENTRE_Z:   centre_z_reg   <= cfg_data[W-1:0];
                REG_PLANE_X:    plane_x_reg    <= cfg_data[W-1:0];
                REG_PIXEL_GAIN: pixel_gain_reg <= cfg_data[GAIN_BITS-1:0];
                REG_SCREEN_W:   screen_w_reg   <= cfg_data[SIZE_BITS-1:0];
                REG_SCREEN_H:   screen_h_reg   <= cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 0: input capture.
    logic                v0_reg;
    logic signed [W-1:0] x0_reg, y0_reg, z0_reg;

    // Stage 1: differences and magnitudes.
    lpp_ctl_t            c1_reg, c1_next;
    logic [W:0]          mn1_reg, md1_reg, mdy1_reg, mdz1_reg;
    logic [W:0]          mn1_next, md1_next, mdy1_next, mdz1_next;
    logic [W-1:0]        mx1_reg, my1_reg, mz1_reg, mx1_next, my1_next, mz1_next;
    logic signed [W-1:0] y1_reg, z1_reg;
    logic signed [W:0]   n_s, d_s, dy_s, dz_s;

    // Stage 2: products.
    lpp_ctl_t            c2_reg;
    logic [NB-1:0]       py2_reg, pz2_reg;
    logic [2*W-1:0]      sx2_reg, sy2_reg, sz2_reg;
    logic [W:0]          md2_reg;
    logic signed [W-1:0] y2_reg, z2_reg;

    // Stage 3: sum of squares.
    lpp_ctl_t            c3_reg;
    logic [NB-1:0]       py3_reg, pz3_reg, s3_reg;
    logic [W:0]          md3_reg;
    logic signed [W-1:0] y3_reg, z3_reg;

    lpp_ctl_t            cd;
    logic [NB-1:0]       qy_d, qz_d;
    logic [W:0]          root_d;
    logic signed [W-1:0] y_d, z_d;

    // Stage 4: quotient clamp and range clamp.
    lpp_ctl_t            c4_reg, c4_next;
    logic [QMW-1:0]      qmy4_reg, qmz4_reg, qmy4_next, qmz4_next;
    logic [W-1:0]        r4_reg, r4_next;
    logic signed [W-1:0] y4_reg, z4_reg;
    logic [QXW-1:0]      qy_x, qz_x;

    // Stage 5: projected values.
    lpp_ctl_t            c5_reg;
    logic signed [VW-1:0] vpy5_reg, vpz5_reg, vpy5_next, vpz5_next;
    logic [W-1:0]        r5_reg;

    // Stage 6: magnitudes of the projected values.
    lpp_ctl_t            c6_reg;
    logic [QMW-1:0]      ay6_reg, az6_reg, ay6_next, az6_next;
    logic                ny6_reg, nz6_reg;
    logic [W-1:0]        r6_reg;

    // Stage 7: pixel gain.
    lpp_ctl_t            c7_reg;
    logic [MW-1:0]       my7_reg, mz7_reg;
    logic                ny7_reg, nz7_reg;
    logic [W-1:0]        r7_reg;

    // Stage 8: offsets and saturation, the output register.
    logic [W-1:0]        ix8_reg, iy8_reg, r8_reg, ix8_next, iy8_next;
    logic                dz8_reg, ov8_reg, ov8_next;
    logic                ovx, ovy;
    logic [W-1:0]        pxv, pyv;

    function automatic logic [W:0] pix_sat(input logic [MW-1:0] m, input logic vneg,
                                           input logic [SIZE_BITS-1:0] size);
        logic [MW:0] off;
        logic [MW:0] m2;
        logic        rneg;
        logic [W:0]  res;
        off  = (MW+1)'({size[SIZE_BITS-1:1], {F{1'b0}}});
        rneg = 1'b0;
        if (!vneg)
        begin
            m2 = {1'b0, m} + off;
        end
        else if ({1'b0, m} >= off)
        begin
            m2   = {1'b0, m} - off;
            rneg = 1'b1;
        end
        else
        begin
            m2 = off - {1'b0, m};
        end
        if (rneg)
        begin
            if (m2 > ((MW+1)'(1) << (W-1)))
                res = {1'b1, 1'b1, {(W-1){1'b0}}};
            else
                res = {1'b0, W'(~m2[W-1:0] + W'(1))};
        end
        else
        begin
            if (m2 > (((MW+1)'(1) << (W-1)) - (MW+1)'(1)))
                res = {1'b1, 1'b0, {(W-1){1'b1}}};
            else
                res = {1'b0, m2[W-1:0]};
        end
        return res;
    endfunction

    always_comb
    begin
        n_s  = {plane_x_reg[W-1], plane_x_reg} - {x0_reg[W-1], x0_reg};
        d_s  = {x0_reg[W-1], x0_reg} - {centre_x_reg[W-1], centre_x_reg};
        dy_s = {y0_reg[W-1], y0_reg} - {centre_y_reg[W-1], centre_y_reg};
        dz_s = {z0_reg[W-1], z0_reg} - {centre_z_reg[W-1], centre_z_reg};
        mn1_next  = n_s[W]  ? -n_s  : n_s;
        md1_next  = d_s[W]  ? -d_s  : d_s;
        mdy1_next = dy_s[W] ? -dy_s : dy_s;
        mdz1_next = dz_s[W] ? -dz_s : dz_s;
        mx1_next  = x0_reg[W-1] ? W'(-x0_reg) : x0_reg;
        my1_next  = y0_reg[W-1] ? W'(-y0_reg) : y0_reg;
        mz1_next  = z0_reg[W-1] ? W'(-z0_reg) : z0_reg;
        c1_next.valid   = v0_reg;
        c1_next.dzero   = (x0_reg == centre_x_reg);
        c1_next.neg_y   = n_s[W] ^ dy_s[W] ^ d_s[W];
        c1_next.neg_z   = n_s[W] ^ dz_s[W] ^ d_s[W];
        c1_next.rng_ovf = 1'b0;
    end

    always_comb
    begin
        qy_x      = QXW'(qy_d);
        qz_x      = QXW'(qz_d);
        qmy4_next = (qy_x > (QXW'(1) << QCLAMP_EXP)) ? (QMW'(1) << QCLAMP_EXP)
                                                       : qy_x[QMW-1:0];
        qmz4_next = (qz_x > (QXW'(1) << QCLAMP_EXP)) ? (QMW'(1) << QCLAMP_EXP)
                                                       : qz_x[QMW-1:0];
        r4_next   = root_d[W] ? {W{1'b1}} : root_d[W-1:0];
        c4_next   = cd;
        c4_next.rng_ovf = root_d[W];
    end

    always_comb
    begin
        vpy5_next = c4_reg.neg_y ? (VW'(y4_reg) - $signed({1'b0, qmy4_reg}))
                                 : (VW'(y4_reg) + $signed({1'b0, qmy4_reg}));
        vpz5_next = c4_reg.neg_z ? (VW'(z4_reg) - $signed({1'b0, qmz4_reg}))
                                 : (VW'(z4_reg) + $signed({1'b0, qmz4_reg}));
        ay6_next  = vpy5_reg[VW-1] ? QMW'(-vpy5_reg) : vpy5_reg[QMW-1:0];
        az6_next  = vpz5_reg[VW-1] ? QMW'(-vpz5_reg) : vpz5_reg[QMW-1:0];
    end

    always_comb
    begin
        {ovx, pxv} = pix_sat(my7_reg, ny7_reg, screen_w_reg);
        {ovy, pyv} = pix_sat(mz7_reg, nz7_reg, screen_h_reg);
        ix8_next   = c7_reg.dzero ? '0 : pxv;
        iy8_next   = c7_reg.dzero ? '0 : pyv;
        ov8_next   = c7_reg.rng_ovf || (!c7_reg.dzero && (ovx || ovy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            c4_reg        <= '0;
            c5_reg        <= '0;
            c6_reg        <= '0;
            c7_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= s_tvalid;
            c1_reg        <= c1_next;
            c2_reg        <= c1_reg;
            c3_reg        <= c2_reg;
            c4_reg        <= c4_next;
            c5_reg        <= c4_reg;
            c6_reg        <= c5_reg;
            c7_reg        <= c6_reg;
            out_valid_reg <= c7_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= s_tdata[W-1:0];
            y0_reg   <= s_tdata[2*W-1:W];
            z0_reg   <= s_tdata[3*W-1:2*W];

            mn1_reg  <= mn1_next;
            md1_reg  <= md1_next;
            mdy1_reg <= mdy1_next;
            mdz1_reg <= mdz1_next;
            mx1_reg  <= mx1_next;
            my1_reg  <= my1_next;
            mz1_reg  <= mz1_next;
            y1_reg   <= y0_reg;
            z1_reg   <= z0_reg;

            py2_reg  <= mn1_reg * mdy1_reg;
            pz2_reg  <= mn1_reg * mdz1_reg;
            sx2_reg  <= mx1_reg * mx1_reg;
            sy2_reg  <= my1_reg * my1_reg;
            sz2_reg  <= mz1_reg * mz1_reg;
            md2_reg  <= md1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;

            py3_reg  <= py2_reg;
            pz3_reg  <= pz2_reg;
            s3_reg   <= NB'(sx2_reg) + NB'(sy2_reg) + NB'(sz2_reg);
            md3_reg  <= md2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;

            qmy4_reg <= qmy4_next;
            qmz4_reg <= qmz4_next;
            r4_reg   <= r4_next;
            y4_reg   <= y_d;
            z4_reg   <= z_d;

            vpy5_reg <= vpy5_next;
            vpz5_reg <= vpz5_next;
            r5_reg   <= r4_reg;

            ay6_reg  <= ay6_next;
            az6_reg  <= az6_next;
            ny6_reg  <= vpy5_reg[VW-1];
            nz6_reg  <= vpz5_reg[VW-1];
            r6_reg   <= r5_reg;

            my7_reg  <= ay6_reg * pixel_gain_reg;
            mz7_reg  <= az6_reg * pixel_gain_reg;
            ny7_reg  <= ny6_reg;
            nz7_reg  <= nz6_reg;
            r7_reg   <= r6_reg;

            ix8_reg  <= ix8_next;
            iy8_reg  <= iy8_next;
            r8_reg   <= r7_reg;
            dz8_reg  <= c7_reg.dzero;
            ov8_reg  <= ov8_next;
        end
    end

    lpp_divsqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (c3_reg),
        .in_num_y (py3_reg),
        .in_num_z (pz3_reg),
        .in_den   (md3_reg),
        .in_rad   (s3_reg),
        .in_vy    (y3_reg),
        .in_vz    (z3_reg),
        .out_ctl  (cd),
        .out_q_y  (qy_d),
        .out_q_z  (qz_d),
        .out_root (root_d),
        .out_vy   (y_d),
        .out_vz   (z_d)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'({r8_reg, iy8_reg, ix8_reg});
    assign m_tuser  = {ov8_reg, dz8_reg};

endmodule

@@ hw/rtl/lpp_divsqrt.sv @@
// ============================================================================
// lpp_divsqrt: pipelined restoring divider pair and integer square root
// Each stage retires one quotient bit for both projected axes and, in the
// first stages, one root bit of the squared range.
// ============================================================================
module lpp_divsqrt #(
    parameter int COORD_BITS = lpp_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  lpp_pkg::lpp_ctl_t            in_ctl,
    input  logic [2*COORD_BITS+1:0]      in_num_y,
    input  logic [2*COORD_BITS+1:0]      in_num_z,
    input  logic [COORD_BITS:0]          in_den,
    input  logic [2*COORD_BITS+1:0]      in_rad,
    input  logic signed [COORD_BITS-1:0] in_vy,
    input  logic signed [COORD_BITS-1:0] in_vz,
    output lpp_pkg::lpp_ctl_t            out_ctl,
    output logic [2*COORD_BITS+1:0]      out_q_y,
    output logic [2*COORD_BITS+1:0]      out_q_z,
    output logic [COORD_BITS:0]          out_root,
    output logic signed [COORD_BITS-1:0] out_vy,
    output logic signed [COORD_BITS-1:0] out_vz
);
    import lpp_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int NB = 2 * W + 2;
    localparam int SS = W + 1;
    localparam int RB = W + 4;

    lpp_ctl_t                pv_ctl   [0:NB];
    logic [NB-1:0]           pv_nq_y  [0:NB];
    logic [NB-1:0]           pv_nq_z  [0:NB];
    logic [W:0]              pv_rem_y [0:NB];
    logic [W:0]              pv_rem_z [0:NB];
    logic [W:0]              pv_den   [0:NB];
    logic [NB-1:0]           pv_rad   [0:NB];
    logic [RB-1:0]           pv_srem  [0:NB];
    logic [W:0]              pv_root  [0:NB];
    logic signed [W-1:0]     pv_vy    [0:NB];
    logic signed [W-1:0]     pv_vz    [0:NB];

    assign pv_ctl[0]   = in_ctl;
    assign pv_nq_y[0]  = in_num_y;
    assign pv_nq_z[0]  = in_num_z;
    assign pv_rem_y[0] = '0;
    assign pv_rem_z[0] = '0;
    assign pv_den[0]   = in_den;
    assign pv_rad[0]   = in_rad;
    assign pv_srem[0]  = '0;
    assign pv_root[0]  = '0;
    assign pv_vy[0]    = in_vy;
    assign pv_vz[0]    = in_vz;

    for (genvar i = 0; i < NB; i++) begin : g_stage
        lpp_ctl_t            ctl_reg;
        logic [NB-1:0]       nq_y_reg, nq_z_reg, nq_y_next, nq_z_next;
        logic [W:0]          rem_y_reg, rem_z_reg, rem_y_next, rem_z_next;
        logic [W:0]          den_reg;
        logic [NB-1:0]       rad_reg, rad_next;
        logic [RB-1:0]       srem_reg, srem_next;
        logic [W:0]          root_reg, root_next;
        logic signed [W-1:0] vy_reg, vz_reg;
        logic [W+1:0]        ry2, rz2, dext;
        logic                gy, gz;

        always_comb
        begin
            dext       = {1'b0, pv_den[i]};
            ry2        = {pv_rem_y[i], pv_nq_y[i][NB-1]};
            rz2        = {pv_rem_z[i], pv_nq_z[i][NB-1]};
            gy         = (ry2 >= dext);
            gz         = (rz2 >= dext);
            rem_y_next = gy ? (W+1)'(ry2 - dext) : ry2[W:0];
            rem_z_next = gz ? (W+1)'(rz2 - dext) : rz2[W:0];
            nq_y_next  = {pv_nq_y[i][NB-2:0], gy};
            nq_z_next  = {pv_nq_z[i][NB-2:0], gz};
        end

        if (i < SS) begin : g_sqrt
            logic [RB-1:0] rr2, trial;
            logic          gs;
            always_comb
            begin
                rr2       = {pv_srem[i][RB-3:0], pv_rad[i][NB-1:NB-2]};
                trial     = RB'({pv_root[i], 2'b01});
                gs        = (rr2 >= trial);
                srem_next = gs ? (rr2 - trial) : rr2;
                root_next = {pv_root[i][W-1:0], gs};
                rad_next  = {pv_rad[i][NB-3:0], 2'b00};
            end
        end else begin : g_hold
            always_comb
            begin
                srem_next = pv_srem[i];
                root_next = pv_root[i];
                rad_next  = pv_rad[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg <= '0;
            end
            else if (en)
            begin
                ctl_reg <= pv_ctl[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_y_reg  <= nq_y_next;
                nq_z_reg  <= nq_z_next;
                rem_y_reg <= rem_y_next;
                rem_z_reg <= rem_z_next;
                den_reg   <= pv_den[i];
                rad_reg   <= rad_next;
                srem_reg  <= srem_next;
                root_reg  <= root_next;
                vy_reg    <= pv_vy[i];
                vz_reg    <= pv_vz[i];
            end
        end

        assign pv_ctl[i+1]   = ctl_reg;
        assign pv_nq_y[i+1]  = nq_y_reg;
        assign pv_nq_z[i+1]  = nq_z_reg;
        assign pv_rem_y[i+1] = rem_y_reg;
        assign pv_rem_z[i+1] = rem_z_reg;
        assign pv_den[i+1]   = den_reg;
        assign pv_rad[i+1]   = rad_reg;
        assign pv_srem[i+1]  = srem_reg;
        assign pv_root[i+1]  = root_reg;
        assign pv_vy[i+1]    = vy_reg;
        assign pv_vz[i+1]    = vz_reg;
    end

    assign out_ctl  = pv_ctl[NB];
    assign out_q_y  = pv_nq_y[NB];
    assign out_q_z  = pv_nq_z[NB];
    assign out_root = pv_root[NB];
    assign out_vy   = pv_vy[NB];
    assign out_vz   = pv_vz[NB];

endmodule
